[rtl/core/slps_pkg.sv]
// ----------------------------------------------------------------------------
// slps_pkg
// Types, constants and timing tables shared by the status LED sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package slps_pkg;

  localparam int unsigned BLINK_W  = 11;  // blink time register width
  localparam int unsigned CYCLE_W  = 13;  // position within a pattern cycle
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    PAT_STARTUP    = 3'd0,
    PAT_IDLE       = 3'd1,
    PAT_CONNECTED  = 3'd2,
    PAT_IMU_FAIL   = 3'd3,
    PAT_ADC_FAIL   = 3'd4,
    PAT_MOTOR_FAIL = 3'd5,
    PAT_CLASS_FAIL = 3'd6,
    PAT_WIFI_FAIL  = 3'd7
  } pattern_e;

  typedef enum logic {
    CFG_BLINK_ON  = 1'b0,
    CFG_BLINK_OFF = 1'b1
  } cfg_idx_e;

  localparam logic [BLINK_W-1:0] BLINK_RESET_MS = 11'd500;

  // pulse patterns
  localparam int unsigned PULSE_ON_MS     = 200;
  localparam int unsigned PULSE_PERIOD_MS = 400;
  localparam int unsigned PULSE_MAX       = 4;
  localparam logic [CYCLE_W-1:0] PULSE_ONE_CYCLE_MS  = 13'd2000;
  localparam logic [CYCLE_W-1:0] PULSE_MANY_CYCLE_MS = 13'd2200;

  // SOS: three dots, three dashes, three dots
  localparam int unsigned SOS_MARKS = 9;
  localparam logic [CYCLE_W-1:0] SOS_CYCLE_MS = 13'd6600;
  localparam logic [CYCLE_W-1:0] SOS_START [SOS_MARKS] = '{
    13'd0, 13'd400, 13'd800, 13'd1600, 13'd2400, 13'd3200, 13'd4400, 13'd4800, 13'd5200
  };
  localparam logic [CYCLE_W-1:0] SOS_END [SOS_MARKS] = '{
    13'd200, 13'd600, 13'd1000, 13'd2200, 13'd3000, 13'd3800, 13'd4600, 13'd5000, 13'd5400
  };

  typedef struct packed {
    logic [BLINK_W-1:0] on_ms;
    logic [BLINK_W-1:0] off_ms;
  } cfg_t;

  typedef struct packed {
    pattern_e           pattern;
    logic [CYCLE_W-1:0] cycle_next;
    logic               red;
    logic               green;
    logic               blue;
  } eval_t;

endpackage

`default_nettype wire

[rtl/core/slps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// slps_cfg_regs
// Blink on/off time registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_cfg_regs (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire                               cfg_idx_i,
  input  wire  [slps_pkg::BLINK_W-1:0]      cfg_wdata_i,
  output slps_pkg::cfg_t                    cfg_o
);
  import slps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLINK_ON:  cfg_d.on_ms  = cfg_wdata_i;
        CFG_BLINK_OFF: cfg_d.off_ms = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_ms  <= BLINK_RESET_MS;
      cfg_q.off_ms <= BLINK_RESET_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/slps_pattern_eval.sv]
// ----------------------------------------------------------------------------
// slps_pattern_eval
// One tick of the pattern sequencer: latch/restart, lit decode, next position.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_pattern_eval (
  input  wire  [2:0]                     req_i,
  input  slps_pkg::pattern_e             active_i,
  input  wire  [slps_pkg::CYCLE_W-1:0]   cycle_i,
  input  slps_pkg::cfg_t                 cfg_i,
  output slps_pkg::eval_t                eval_o
);
  import slps_pkg::*;

  pattern_e           req;
  pattern_e           pat;
  logic               is_blink;
  logic               restart;
  logic [CYCLE_W-1:0] t;
  logic [CYCLE_W-1:0] on_ext;
  logic [BLINK_W:0]   blink_len;
  logic [CYCLE_W-1:0] len;
  logic [2:0]         pulse_cnt;
  logic               lit_pulse;
  logic               lit_sos;
  logic               lit;
  logic [CYCLE_W:0]   t_inc;

  assign req      = pattern_e'(req_i);
  assign on_ext   = CYCLE_W'(cfg_i.on_ms);
  assign is_blink = (active_i == PAT_STARTUP) || (active_i == PAT_IDLE) ||
                    (active_i == PAT_CONNECTED);
  // blink patterns give way at the end of the lit phase when the request moved
  assign restart  = (cycle_i != '0) && is_blink && (cycle_i == on_ext) && (req != active_i);
  assign pat      = ((cycle_i == '0) || restart) ? req : active_i;
  assign t        = restart ? '0 : cycle_i;

  assign blink_len = {1'b0, cfg_i.on_ms} + {1'b0, cfg_i.off_ms};
  assign pulse_cnt = 3'(pat) - 3'd2;

  always_comb begin
    lit_pulse = 1'b0;
    for (int k = 0; k < PULSE_MAX; k++) begin
      if ((3'(k) < pulse_cnt) &&
          (t >= CYCLE_W'(k * PULSE_PERIOD_MS)) &&
          (t <  CYCLE_W'(k * PULSE_PERIOD_MS + PULSE_ON_MS))) begin
        lit_pulse = 1'b1;
      end
    end
  end

  always_comb begin
    lit_sos = 1'b0;
    for (int i = 0; i < SOS_MARKS; i++) begin
      if ((t >= SOS_START[i]) && (t < SOS_END[i])) begin
        lit_sos = 1'b1;
      end
    end
  end

  always_comb begin
    lit = 1'b0;
    len = SOS_CYCLE_MS;
    case (pat)
      PAT_STARTUP, PAT_IDLE, PAT_CONNECTED: begin
        lit = (t < on_ext);
        len = (blink_len == '0) ? CYCLE_W'(1) : CYCLE_W'(blink_len);
      end
      PAT_IMU_FAIL: begin
        lit = lit_pulse;
        len = PULSE_ONE_CYCLE_MS;
      end
      PAT_ADC_FAIL, PAT_MOTOR_FAIL, PAT_CLASS_FAIL: begin
        lit = lit_pulse;
        len = PULSE_MANY_CYCLE_MS;
      end
      PAT_WIFI_FAIL: begin
        lit = lit_sos;
        len = SOS_CYCLE_MS;
      end
      default: begin
        lit = 1'b0;
        len = SOS_CYCLE_MS;
      end
    endcase
  end

  assign t_inc = {1'b0, t} + 1'b1;

  always_comb begin
    eval_o.pattern    = pat;
    eval_o.cycle_next = (t_inc >= {1'b0, len}) ? '0 : t_inc[CYCLE_W-1:0];
    eval_o.red        = 1'b0;
    eval_o.green      = 1'b0;
    eval_o.blue       = 1'b0;
    if (lit) begin
      case (pat)
        PAT_STARTUP:   eval_o.blue  = 1'b1;
        PAT_IDLE: begin
          eval_o.red   = 1'b1;
          eval_o.green = 1'b1;
        end
        PAT_CONNECTED: eval_o.green = 1'b1;
        default: begin
          eval_o.red  = 1'b1;
          eval_o.blue = 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/status_led_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// status_led_pattern_sequencer
// Per-millisecond RGB status pattern generator with two flag indicator LEDs.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the requested pattern code
// and the motor and logging flags; each item yields exactly one result item
// with the RGB on-bits and copies of the two flags. Items flow through two
// registers: an input register and a result register, with the pattern
// evaluation (latch, lit decode, cycle position update) in between. The block
// accepts one item per clock cycle while results are taken. An accepted item
// waits in the input register; its result is registered for m_axis in the
// result register. The rate is set by the state update (active pattern and
// cycle position) that each item performs before the next one is evaluated.
// While a result waits, the input register can still take one item; with
// both registers full, s_axis_tready drops until the result is taken. Blink
// times come through the cfg port and take effect on the next evaluated item.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_sequencer (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,     // 0 on time, 1 off time (ms)
  input  wire  [slps_pkg::BLINK_W-1:0]     cfg_wdata_i,
  // tick input
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [slps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [2:0] requested_pattern,
                                                          // [3] motor_moving,
                                                          // [4] logging_active,
                                                          // [7:5] zero
  // LED result output
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [slps_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [0] red_on, [1] green_on,
                                                          // [2] blue_on, [3] motor_led,
                                                          // [4] logging_led, [7:5] zero
);
  import slps_pkg::*;

  cfg_t  cfg;
  eval_t eval;

  // input register
  logic               in_vld_q;
  logic [2:0]         in_req_q;
  logic               in_motor_q;
  logic               in_log_q;
  // sequencer state
  pattern_e           active_q, active_d;
  logic [CYCLE_W-1:0] cycle_q, cycle_d;
  // result register
  logic               out_vld_q, out_vld_d;
  logic [4:0]         out_data_q;

  logic out_free;
  logic in_adv;
  logic s_fire;

  // result register can load when empty or being drained this cycle
  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_adv        = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  slps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slps_pattern_eval u_eval (
    .req_i    (in_req_q),
    .active_i (active_q),
    .cycle_i  (cycle_q),
    .cfg_i    (cfg),
    .eval_o   (eval)
  );

  // state advances only when an item moves into the result register
  always_comb begin
    active_d  = in_adv ? eval.pattern    : active_q;
    cycle_d   = in_adv ? eval.cycle_next : cycle_q;
    out_vld_d = in_adv ? 1'b1 : (out_free ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      active_q  <= PAT_STARTUP;
      cycle_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      out_vld_q <= out_vld_d;
      active_q  <= active_d;
      cycle_q   <= cycle_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q   <= s_axis_tdata[2:0];
      in_motor_q <= s_axis_tdata[3];
      in_log_q   <= s_axis_tdata[4];
    end
    if (in_adv) begin
      out_data_q <= {in_log_q, in_motor_q, eval.blue, eval.green, eval.red};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data_q);

endmodule

`default_nettype wire

[rtl/core/slps_checker.sv]
// ----------------------------------------------------------------------------
// slps_checker
// Port-level checks for the status LED sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slps_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [slps_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // no result is pending once reset has been seen at an edge
  a_rst_no_valid: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // only the defined colors appear: blue, yellow, green, purple or dark
  a_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]) &&
                      (!m_axis_tdata[0] || m_axis_tdata[1] || m_axis_tdata[2]))
    else $error("undefined RGB combination");

  // with the result side free the input side is never blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output is ready");

endmodule

bind status_led_pattern_sequencer slps_checker u_slps_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the status LED pattern sequencer. A short table of
// directed ticks is followed by random runs of held pattern requests under
// several blink settings and idling mixes. Typed rows are compared with their
// table entries, the rest with an in-bench cycle-position sequencer model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slps_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT   = 2000;  // cycles with no handshake
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // one LED result item
  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic motor;
    logic logging;
  } leds_t;

  // directed table row: either a tick or a blink-time update
  typedef struct packed {
    logic       is_cfg;
    pattern_e   req;
    logic       motor;
    logic       logging;
    logic [10:0] lit_ms;
    logic [10:0] dark_ms;
    logic       typed;   // leds below hold the expected result
    leds_t      leds;
  } row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  cfg_idx_e    cfg_idx_i     = CFG_BLINK_ON;
  logic [10:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [2:0] requested_pattern, [3] motor_moving,
                                    // [4] logging_active, [7:5] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [0] red_on, [1] green_on, [2] blue_on,
                                    // [3] motor_led, [4] logging_led, [7:5] zero

  // LED results still owed by the block, oldest first
  leds_t       expected_leds[$];
  int unsigned mismatches = 0;

  // pattern model: latched pattern, position in its cycle, blink times
  pattern_e    live_pat = PAT_STARTUP;
  logic [12:0] live_pos = '0;
  logic [10:0] on_ms    = BLINK_RESET_MS;
  logic [10:0] off_ms   = BLINK_RESET_MS;

  // idling knobs; hold_tok is bumped by the stimulus to request a hold-off
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_tok  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet     = 0;

  row_t directed_plan[20];

  status_led_pattern_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Pattern model
  // ---------------------------------------------------------------------------

  // cycle length of a pattern; both blink times zero still gives a 1 ms cycle
  function automatic int unsigned cycle_span(pattern_e pat);
    int unsigned span;
    case (pat)
      PAT_STARTUP, PAT_IDLE, PAT_CONNECTED: begin
        span = 32'(on_ms) + 32'(off_ms);
        if (span == 0) span = 1;
      end
      PAT_IMU_FAIL:  span = 32'(PULSE_ONE_CYCLE_MS);
      PAT_WIFI_FAIL: span = 32'(SOS_CYCLE_MS);
      default:       span = 32'(PULSE_MANY_CYCLE_MS);
    endcase
    return span;
  endfunction

  // SOS marks: dots every 400 ms up to 1000, dashes every 800 ms from 1600,
  // dots again from 4400
  function automatic logic sos_mark(int unsigned t);
    return (t < 1000 && t % 400 < 200) ||
           (t >= 1600 && t < 3800 && (t - 1600) % 800 < 600) ||
           (t >= 4400 && t < 5400 && (t - 4400) % 400 < 200);
  endfunction

  // one millisecond tick: latch, decode the lit phase, advance the position
  function automatic leds_t advance_pattern(pattern_e req, logic motor, logic logging);
    leds_t       leds;
    logic        lit;
    int unsigned t;
    int unsigned pulses;
    int unsigned next;
    if (live_pos == 0) begin
      live_pat = req;
    end else if (live_pat <= PAT_CONNECTED && live_pos == 13'(on_ms) && req != live_pat) begin
      // a blink gives way at the end of its lit phase; the new one starts now
      live_pat = req;
      live_pos = '0;
    end
    t = 32'(live_pos);
    case (live_pat)
      PAT_STARTUP, PAT_IDLE, PAT_CONNECTED: lit = t < 32'(on_ms);
      PAT_WIFI_FAIL: lit = sos_mark(t);
      default: begin
        pulses = int'(live_pat) - 2;
        lit = t < pulses * PULSE_PERIOD_MS && t % PULSE_PERIOD_MS < PULSE_ON_MS;
      end
    endcase
    leds = '0;
    leds.motor   = motor;
    leds.logging = logging;
    if (lit) begin
      case (live_pat)
        PAT_STARTUP: leds.blue = 1'b1;
        PAT_IDLE: begin
          leds.red   = 1'b1;
          leds.green = 1'b1;
        end
        PAT_CONNECTED: leds.green = 1'b1;
        default: begin
          leds.red  = 1'b1;
          leds.blue = 1'b1;
        end
      endcase
    end
    // a position left past the end by a shorter blink setting wraps here too
    next = t + 1;
    if (next >= cycle_span(live_pat)) next = 0;
    live_pos = next[12:0];
    return leds;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  task automatic set_idle(idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
    recv_stall_pct <= (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 26 : 0;
  endtask

  // offer one tick, wait for the handshake, then record what it must light
  task automatic send_tick(pattern_e req, logic motor, logic logging,
                           logic typed, leds_t typed_leds);
    leds_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, logging, motor, req};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_pattern(req, motor, logging);
    expected_leds.push_back(typed ? typed_leds : predicted);
  endtask

  // stop offering and wait until every owed result is out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_leds.size() != 0);
  endtask

  // block must be idle: both registers written on back-to-back cycles
  task automatic set_blink(logic [10:0] lit_ms, logic [10:0] dark_ms);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BLINK_ON;
    cfg_wdata_i <= lit_ms;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BLINK_OFF;
    cfg_wdata_i <= dark_ms;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    on_ms  = lit_ms;
    off_ms = dark_ms;
  endtask

  // random runs of held requests; a few runs are noise with a new code per tick
  task automatic run_phase(idle_mode_e mode, logic [10:0] lit_ms, logic [10:0] dark_ms,
                           int unsigned count, logic hold_off);
    int unsigned sent;
    int unsigned run_len;
    int unsigned roll;
    logic        noise;
    pattern_e    req;
    drain_results();
    set_blink(lit_ms, dark_ms);
    set_idle(mode);
    if (hold_off) hold_tok <= hold_tok + 1;
    sent = 0;
    while (sent < count) begin
      roll  = $urandom_range(0, 99);
      noise = roll < 15;
      req   = pattern_e'($urandom_range(0, 7));
      if (noise) run_len = $urandom_range(1, 3);
      else if (roll > 94) run_len = $urandom_range(400, 2300);
      else run_len = $urandom_range(1, 40);
      for (int unsigned k = 0; k < run_len && sent < count; k++) begin
        if (noise) req = pattern_e'($urandom_range(0, 7));
        send_tick(req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
      // now and then the sender waits for the block to empty out
      if ($urandom_range(0, 39) == 0) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic compare_bit(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_leds(logic [7:0] tdata);
    leds_t want;
    if (expected_leds.size() == 0) begin
      $error("result item with nothing expected: tdata %h", tdata);
      mismatches++;
    end else begin
      want = expected_leds.pop_front();
      compare_bit("red_on",      want.red,     tdata[0]);
      compare_bit("green_on",    want.green,   tdata[1]);
      compare_bit("blue_on",     want.blue,    tdata[2]);
      compare_bit("motor_led",   want.motor,   tdata[3]);
      compare_bit("logging_led", want.logging, tdata[4]);
    end
  endtask

  // receiver: checks at the edge, then picks tready for the next cycle
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_leds(m_axis_tdata);
    if (hold_tok != hold_seen) begin
      hold_seen     <= hold_tok;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // typed rows: right after reset (500/500 blink, startup latched) and with
    // both blink times zero, where every tick is dark
    directed_plan = '{
      //  cfg   req             mot   log   lit      dark     typed r g b m l
      '{1'b0, PAT_STARTUP,    1'b1, 1'b1, 11'd0,   11'd0,   1'b1, 5'b00111},
      '{1'b0, PAT_WIFI_FAIL,  1'b0, 1'b0, 11'd0,   11'd0,   1'b1, 5'b00100},
      '{1'b0, PAT_IMU_FAIL,   1'b1, 1'b0, 11'd0,   11'd0,   1'b1, 5'b00110},
      '{1'b1, PAT_STARTUP,    1'b0, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_IDLE,       1'b0, 1'b1, 11'd0,   11'd0,   1'b1, 5'b00001},
      '{1'b0, PAT_IDLE,       1'b1, 1'b0, 11'd0,   11'd0,   1'b1, 5'b00010},
      '{1'b0, PAT_CONNECTED,  1'b1, 1'b1, 11'd0,   11'd0,   1'b1, 5'b00011},
      // 1 ms lit, 1 ms dark: request changes land on the lit/dark boundary
      '{1'b1, PAT_STARTUP,    1'b0, 1'b0, 11'd1,   11'd1,   1'b0, 5'b00000},
      '{1'b0, PAT_CONNECTED,  1'b0, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_STARTUP,    1'b1, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_STARTUP,    1'b0, 1'b1, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_IDLE,       1'b1, 1'b1, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_CONNECTED,  1'b0, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_CLASS_FAIL, 1'b1, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_MOTOR_FAIL, 1'b0, 1'b1, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_ADC_FAIL,   1'b1, 1'b1, 11'd0,   11'd0,   1'b0, 5'b00000},
      // widest blink times, written while a pulse pattern runs
      '{1'b1, PAT_STARTUP,    1'b0, 1'b0, 11'd2047, 11'd2047, 1'b0, 5'b00000},
      '{1'b0, PAT_WIFI_FAIL,  1'b0, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_STARTUP,    1'b1, 1'b1, 11'd0,   11'd0,   1'b0, 5'b00000},
      '{1'b0, PAT_IMU_FAIL,   1'b0, 1'b0, 11'd0,   11'd0,   1'b0, 5'b00000}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        drain_results();
        set_blink(directed_plan[i].lit_ms, directed_plan[i].dark_ms);
      end else begin
        send_tick(directed_plan[i].req, directed_plan[i].motor, directed_plan[i].logging,
                  directed_plan[i].typed, directed_plan[i].leds);
      end
    end

    // random part: blink settings from zero to the widest, every idling mix;
    // the hold-off phase keeps offering so the block fills and stalls
    run_phase(IDLE_NONE,     11'd1,    11'd1,    150, 1'b0);
    run_phase(IDLE_SENDER,   11'd2047, 11'd2047, 200, 1'b0);
    run_phase(IDLE_RECEIVER, 11'd3,    11'd7,    200, 1'b0);
    run_phase(IDLE_BOTH,     11'd0,    11'd5,    150, 1'b0);
    run_phase(IDLE_NONE,     11'd6,    11'd2,    200, 1'b1);
    run_phase(IDLE_SENDER,   11'($urandom_range(1, 16)), 11'($urandom_range(1, 16)),
              150, 1'b0);
    run_phase(IDLE_RECEIVER, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              150, 1'b0);
    run_phase(IDLE_BOTH,     11'd1,    11'd0,    100, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
